// ===== design/dse_pkg.sv =====
// shared types and constants for the delimited substring extractor
package dse_pkg;

    localparam int BYTE_W  = 8;
    localparam int DELIM_W = 64;
    localparam int LEN_W   = 4;
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 3;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] CFG_LEFT_DELIM  = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_LEFT_LEN    = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_RIGHT_DELIM = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_RIGHT_LEN   = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_FIND_ALL    = 3'd4;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_ABANDON = 2'd2,
        KIND_FINISH  = 2'd3
    } kind_t;

endpackage

// ===== design/delimited_substring_extractor.sv =====
// delimited substring extractor: delimiter windows, piece control and result stage
// path: an input beat passes the input register, then the result stage
// throughput: one input beat per cycle while each item gives at most one result and
// m_tready stays high; an item with more than one result holds the result stage until
// its last result is taken, and one further item waits meanwhile in the input register
// reset: asynchronous, clears control state and all configuration registers to zero
module delimited_substring_extractor #(
    parameter int MAX_DELIM_BYTES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [dse_pkg::ADDR_W-1:0]        cfg_addr,
    input  logic [dse_pkg::DELIM_W-1:0]       cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dse_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] in_byte
    input  logic                              s_tuser,   // [0] has_byte
    input  logic                              s_tlast,   // string_end
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dse_pkg::BYTE_W-1:0]        m_tdata,   // [7:0] out_byte
    output logic [dse_pkg::KIND_W-1:0]        m_tuser,   // [1:0] kind
    output logic                              m_tlast    // last
);
    import dse_pkg::*;

    localparam int WIN_W = 8 * MAX_DELIM_BYTES;
    localparam int CW    = $clog2(MAX_DELIM_BYTES + 1);
    localparam int SH_W  = CW + 3;

    typedef enum logic [1:0] {
        PH_SEEK  = 2'd0,
        PH_PIECE = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [WIN_W-1:0]  win;
        logic [CW-1:0]     cnt;
        logic              popped;
        logic [BYTE_W-1:0] old;
    } push_t;

    // shift a byte into a window of cap bytes, trimming after a length change
    function automatic push_t push_byte(input logic [WIN_W-1:0] win,
                                        input logic [CW-1:0] cnt,
                                        input logic [CW-1:0] cap,
                                        input logic [BYTE_W-1:0] b);
        push_t            r;
        logic [WIN_W-1:0] w1;
        logic [CW-1:0]    c1;
        logic [WIN_W-1:0] w2;
        logic [CW-1:0]    c2;
        if (cnt > cap)
        begin
            w1 = win >> {cnt - cap, 3'b000};
            c1 = cap;
        end
        else
        begin
            w1 = win;
            c1 = cnt;
        end
        r.popped = (c1 == cap);
        r.old    = w1[BYTE_W-1:0];
        if (r.popped)
        begin
            w2 = w1 >> 8;
            c2 = c1 - CW'(1);
        end
        else
        begin
            w2 = w1;
            c2 = c1;
        end
        r.win = w2 | (WIN_W'(b) << {c2, 3'b000});
        r.cnt = c2 + CW'(1);
        return r;
    endfunction

    function automatic logic win_match(input logic [WIN_W-1:0] win,
                                       input logic [CW-1:0] cnt,
                                       input logic [CW-1:0] cap,
                                       input logic [DELIM_W-1:0] delim);
        logic [WIN_W-1:0] mask;
        logic [SH_W-1:0]  sh;
        sh   = {cap, 3'b000};
        mask = ~({WIN_W{1'b1}} << sh);
        return (cnt == cap) && (((win ^ delim[WIN_W-1:0]) & mask) == '0);
    endfunction

    // configuration registers
    logic [DELIM_W-1:0] left_delim_reg;
    logic [LEN_W-1:0]   left_len_reg;
    logic [DELIM_W-1:0] right_delim_reg;
    logic [LEN_W-1:0]   right_len_reg;
    logic               find_all_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_delim_reg  <= '0;
            left_len_reg    <= '0;
            right_delim_reg <= '0;
            right_len_reg   <= '0;
            find_all_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_LEFT_DELIM:  left_delim_reg  <= cfg_data;
                CFG_LEFT_LEN:    left_len_reg    <= cfg_data[LEN_W-1:0];
                CFG_RIGHT_DELIM: right_delim_reg <= cfg_data;
                CFG_RIGHT_LEN:   right_len_reg   <= cfg_data[LEN_W-1:0];
                CFG_FIND_ALL:    find_all_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    logic [CW-1:0] ll;
    logic [CW-1:0] rl;
    assign ll = (left_len_reg > LEN_W'(MAX_DELIM_BYTES)) ? CW'(MAX_DELIM_BYTES)
                                                         : CW'(left_len_reg);
    assign rl = (right_len_reg > LEN_W'(MAX_DELIM_BYTES)) ? CW'(MAX_DELIM_BYTES)
                                                          : CW'(right_len_reg);

    // input register
    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_has_reg;
    logic              in_end_reg;

    // extraction state
    phase_t            phase_reg, phase_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              started_reg, started_next;

    // result stage: slot 0 is on the output
    logic [BYTE_W-1:0] res_byte_reg [3];
    kind_t             res_kind_reg [3];
    logic [1:0]        res_cnt_reg;

    logic [BYTE_W-1:0] res_byte_next [3];
    kind_t             res_kind_next [3];
    logic [1:0]        res_cnt_next;

    logic  pop;
    logic  stage_free;
    logic  advance;
    push_t pb;

    assign m_tvalid   = (res_cnt_reg != 2'd0);
    assign m_tdata    = res_byte_reg[0];
    assign m_tuser    = res_kind_reg[0];
    assign m_tlast    = (res_cnt_reg == 2'd1);
    assign pop        = m_tvalid && m_tready;
    assign stage_free = (res_cnt_reg == 2'd0) || (pop && res_cnt_reg == 2'd1);
    assign advance    = in_vld_reg && stage_free;
    assign s_tready   = !in_vld_reg || advance;

    always_comb
    begin
        phase_next   = phase_reg;
        win_next     = win_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        res_cnt_next = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            res_byte_next[i] = '0;
            res_kind_next[i] = KIND_FINISH;
        end

        // empty left delimiter opens a piece straight away
        if (phase_next == PH_SEEK && ll == '0)
        begin
            phase_next   = PH_PIECE;
            started_next = 1'b0;
            win_next     = '0;
            cnt_next     = '0;
        end

        pb = push_byte(win_next, cnt_next, (phase_next == PH_SEEK) ? ll : rl, in_byte_reg);

        if (in_has_reg)
        begin
            if (phase_next == PH_SEEK)
            begin
                win_next = pb.win;
                cnt_next = pb.cnt;
                if (win_match(pb.win, pb.cnt, ll, left_delim_reg))
                begin
                    phase_next   = PH_PIECE;
                    started_next = 1'b0;
                    win_next     = '0;
                    cnt_next     = '0;
                end
            end
            else if (phase_next == PH_PIECE)
            begin
                if (rl == '0)
                begin
                    res_byte_next[res_cnt_next] = in_byte_reg;
                    res_kind_next[res_cnt_next] = KIND_BYTE;
                    res_cnt_next = res_cnt_next + 2'd1;
                    started_next = 1'b1;
                end
                else
                begin
                    win_next = pb.win;
                    cnt_next = pb.cnt;
                    // byte falling out of the window is clear of the delimiter
                    if (pb.popped)
                    begin
                        res_byte_next[res_cnt_next] = pb.old;
                        res_kind_next[res_cnt_next] = KIND_BYTE;
                        res_cnt_next = res_cnt_next + 2'd1;
                        started_next = 1'b1;
                    end
                    if (win_match(pb.win, pb.cnt, rl, right_delim_reg))
                    begin
                        res_byte_next[res_cnt_next] = '0;
                        res_kind_next[res_cnt_next] = KIND_DONE;
                        res_cnt_next = res_cnt_next + 2'd1;
                        phase_next   = find_all_reg ? PH_SEEK : PH_DONE;
                        started_next = 1'b0;
                        win_next     = '0;
                        cnt_next     = '0;
                    end
                end
            end
        end

        if (in_end_reg)
        begin
            if (phase_next == PH_PIECE)
            begin
                if (rl == '0)
                begin
                    res_byte_next[res_cnt_next] = '0;
                    res_kind_next[res_cnt_next] = KIND_DONE;
                    res_cnt_next = res_cnt_next + 2'd1;
                end
                else if (started_next)
                begin
                    res_byte_next[res_cnt_next] = '0;
                    res_kind_next[res_cnt_next] = KIND_ABANDON;
                    res_cnt_next = res_cnt_next + 2'd1;
                end
            end
            res_byte_next[res_cnt_next] = '0;
            res_kind_next[res_cnt_next] = KIND_FINISH;
            res_cnt_next = res_cnt_next + 2'd1;
            phase_next   = PH_SEEK;
            started_next = 1'b0;
            win_next     = '0;
            cnt_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            phase_reg   <= PH_SEEK;
            win_reg     <= '0;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
            res_cnt_reg <= 2'd0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg   <= phase_next;
                win_reg     <= win_next;
                cnt_reg     <= cnt_next;
                started_reg <= started_next;
                res_cnt_reg <= res_cnt_next;
            end
            else if (pop)
            begin
                res_cnt_reg <= res_cnt_reg - 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_end_reg  <= s_tlast;
        end

        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_byte_reg[i] <= res_byte_next[i];
                res_kind_reg[i] <= res_kind_next[i];
            end
        end
        else if (pop)
        begin
            res_byte_reg[0] <= res_byte_reg[1];
            res_kind_reg[0] <= res_kind_reg[1];
            res_byte_reg[1] <= res_byte_reg[2];
            res_kind_reg[1] <= res_kind_reg[2];
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_DELIM_BYTES))
        else $error("delimiter window holds more bytes than allowed");

    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_FINISH) |-> m_tlast)
        else $error("string finished result is not the last of its item");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |-> (cnt_reg == '0 && !started_reg))
        else $error("window or piece flag left set after piece completed");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> in_vld_reg)
        else $error("waiting input item lost");
`endif

endmodule
